// ----- rtl/gwbm_pkg.sv -----
`default_nettype none

package gwbm_pkg;

  localparam int NUM_CAND    = 7;
  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_LAT  = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QUOT_BITS   = 16;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] EXP_A_Q16 = 16'd45426;
  localparam logic [13:0] EXP_B_Q16 = 14'd12657;
  localparam logic [21:0] X_CAP_Q16 = 22'h200000;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [5:0]  N_CUTOFF  = 6'd40;

  localparam logic [3:0]  NUM_FRAMES_RST   = 4'd1;
  localparam logic [47:0] WEIGHT_SCALE_RST = 48'h0080_0000_0000;

  typedef enum logic {
    REG_NUM_FRAMES   = 1'b0,
    REG_WEIGHT_SCALE = 1'b1
  } gwbm_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0]                ref_s;
    logic [NUM_CAND-1:0][SAMPLE_W-1:0]  cand;
    logic [NUM_CAND-1:0][SAMPLE_W-1:0]  delta;
    logic [NUM_CAND-1:0]                en;
  } gwbm_item_t;

endpackage

`default_nettype wire

// ----- rtl/gwbm_if.sv -----
`default_nettype none

interface gwbm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ref_sample;
  logic [15:0] cand_sample_a;
  logic [15:0] cand_sample_b;
  logic [15:0] cand_sample_c;
  logic [15:0] cand_sample_d;
  logic [15:0] cand_sample_e;
  logic [15:0] cand_sample_f;
  logic [15:0] cand_sample_g;
  logic [6:0]  inside_mask;

  modport source (
    output valid, ref_sample, cand_sample_a, cand_sample_b, cand_sample_c,
           cand_sample_d, cand_sample_e, cand_sample_f, cand_sample_g, inside_mask,
    input  ready
  );
  modport sink (
    input  valid, ref_sample, cand_sample_a, cand_sample_b, cand_sample_c,
           cand_sample_d, cand_sample_e, cand_sample_f, cand_sample_g, inside_mask,
    output ready
  );
endinterface

interface gwbm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] merged_sample;

  modport source (output valid, merged_sample, input ready);
  modport sink (input valid, merged_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/gwbm_front.sv -----
`default_nettype none

module gwbm_front import gwbm_pkg::*; #(
  parameter int MAX_FRAMES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gwbm_in_if.sink         in_ch,
  input  wire logic [3:0] num_frames,
  output logic            push_valid,
  output gwbm_item_t      push_item,
  input  wire logic       push_ready
);

  logic                                fv;
  gwbm_item_t                          item;
  logic [3:0]                          frames;
  logic [NUM_CAND-1:0][SAMPLE_W-1:0]   cand;
  gwbm_item_t                          item_next;

  assign in_ch.ready = !fv || push_ready;
  assign push_valid  = fv;
  assign push_item   = item;

  always_comb begin
    frames = (num_frames > 4'(MAX_FRAMES)) ? 4'(MAX_FRAMES) : num_frames;
    cand[0] = in_ch.cand_sample_a;
    cand[1] = in_ch.cand_sample_b;
    cand[2] = in_ch.cand_sample_c;
    cand[3] = in_ch.cand_sample_d;
    cand[4] = in_ch.cand_sample_e;
    cand[5] = in_ch.cand_sample_f;
    cand[6] = in_ch.cand_sample_g;
    item_next.ref_s = in_ch.ref_sample;
    item_next.cand  = cand;
    for (int k = 0; k < NUM_CAND; k++) begin
      item_next.delta[k] = (cand[k] >= in_ch.ref_sample) ? cand[k] - in_ch.ref_sample
                                                         : in_ch.ref_sample - cand[k];
      item_next.en[k] = in_ch.inside_mask[k] && (4'(k + 1) < frames);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ch.ready) begin
      fv <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gwbm_queue.sv -----
`default_nettype none

module gwbm_queue import gwbm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  input  wire gwbm_item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output gwbm_item_t      pop_item,
  input  wire logic       pop_ready
);

  gwbm_item_t        entries [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   cnt;
  logic              push;
  logic              pop;

  assign push_ready = cnt != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_item   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/gwbm_weight.sv -----
`default_nettype none

module gwbm_weight import gwbm_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [15:0]                 delta,
  input  wire logic [47:0]                 weight_scale,
  output logic      [WEIGHT_FRAC_BITS:0]   weight
);

  logic [31:0] d2;
  logic [55:0] phi;
  logic [55:0] plo;
  logic [56:0] xs;
  logic [21:0] xc;
  logic [38:0] yp;
  logic [5:0]  n4;
  logic [15:0] f4;
  logic [31:0] ffp;
  logic [31:0] fap;
  logic [15:0] ff5;
  logic [15:0] fa5;
  logic [5:0]  n5;
  logic [29:0] fbp;
  logic [16:0] m6;
  logic [5:0]  n6;
  logic [16+WEIGHT_FRAC_BITS:0] shv;
  logic [16+WEIGHT_FRAC_BITS:0] shr;
  logic [6:0]  amt;

  always_comb begin
    xs  = 57'(phi) + 57'(plo >> 24);
    yp  = 39'(xc) * 39'(LOG2E_Q16);
    ffp = 32'(f4) * 32'(f4);
    fap = 32'(f4) * 32'(EXP_A_Q16);
    fbp = 30'(ff5) * 30'(EXP_B_Q16);
    shv = {m6, {WEIGHT_FRAC_BITS{1'b0}}};
    amt = 7'(n6) + 7'd16;
    shr = shv >> amt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= 32'(delta) * 32'(delta);
      phi <= 56'(d2) * 56'(weight_scale[47:24]);
      plo <= 56'(d2) * 56'(weight_scale[23:0]);
      xc  <= (xs >= 57'(X_CAP_Q16)) ? X_CAP_Q16 : xs[21:0];
      n4  <= yp[37:32];
      f4  <= yp[31:16];
      ff5 <= ffp[31:16];
      fa5 <= fap[31:16];
      n5  <= n4;
      m6  <= ONE_Q16 + 17'(fbp[29:16]) - 17'(fa5);
      n6  <= n5;
      weight <= (n6 >= N_CUTOFF) ? '0 : shr[WEIGHT_FRAC_BITS:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gwbm_back.sv -----
`default_nettype none

module gwbm_back import gwbm_pkg::*; #(
  parameter int MAX_FRAMES       = 8,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire gwbm_item_t  in_item,
  output logic             in_ready,
  input  wire logic [47:0] weight_scale,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_sample
);

  localparam int NL = MAX_FRAMES - 1;
  localparam int WW = WEIGHT_FRAC_BITS + 1;
  localparam int PW = WEIGHT_FRAC_BITS + 17;
  localparam int NW = WEIGHT_FRAC_BITS + 20;
  localparam int DW = WEIGHT_FRAC_BITS + 4;

  logic                   adv;
  gwbm_item_t             dl [0:WEIGHT_LAT];
  logic [WEIGHT_LAT:0]    vd;
  logic [NL-1:0][WW-1:0]  w;
  logic [NL-1:0][PW-1:0]  prod;
  logic [NL-1:0][WW-1:0]  wq;
  logic [15:0]            ref8;
  logic                   v8;
  logic [NW-1:0]          num_sum;
  logic [DW-1:0]          den_sum;
  logic [NW-1:0]          drem [0:QUOT_BITS];
  logic [DW-1:0]          dden [0:QUOT_BITS];
  logic [QUOT_BITS-1:0]   dq   [0:QUOT_BITS];
  logic [QUOT_BITS:0]     dv;

  assign adv        = !dv[QUOT_BITS] || out_ready;
  assign in_ready   = adv;
  assign out_valid  = dv[QUOT_BITS];
  assign out_sample = dq[QUOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
      v8 <= 1'b0;
      dv <= '0;
    end else if (adv) begin
      vd <= {vd[WEIGHT_LAT-1:0], in_valid};
      v8 <= vd[WEIGHT_LAT];
      dv <= {dv[QUOT_BITS-1:0], v8};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= in_item;
      for (int i = 1; i <= WEIGHT_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_lane
    gwbm_weight #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_weight (
      .clk          (clk),
      .en           (adv),
      .delta        (dl[0].delta[k]),
      .weight_scale (weight_scale),
      .weight       (w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ref8 <= dl[WEIGHT_LAT].ref_s;
      for (int k = 0; k < NL; k++) begin
        prod[k] <= dl[WEIGHT_LAT].en[k] ? PW'(w[k]) * PW'(dl[WEIGHT_LAT].cand[k]) : '0;
        wq[k]   <= dl[WEIGHT_LAT].en[k] ? w[k] : '0;
      end
    end
  end

  always_comb begin
    num_sum = NW'(ref8) << WEIGHT_FRAC_BITS;
    den_sum = DW'(1) << WEIGHT_FRAC_BITS;
    for (int k = 0; k < NL; k++) begin
      num_sum = num_sum + NW'(prod[k]);
      den_sum = den_sum + DW'(wq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drem[0] <= num_sum;
      dden[0] <= den_sum;
      dq[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_div
    localparam int B = QUOT_BITS - j;
    logic [NW-1:0] dsh;
    logic          ge;

    always_comb begin
      dsh = NW'(dden[j-1]) << B;
      ge  = drem[j-1] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem[j] <= ge ? drem[j-1] - dsh : drem[j-1];
        dden[j] <= dden[j-1];
        dq[j]   <= dq[j-1] | (QUOT_BITS'(ge) << B);
      end
    end
  end

  a_den_floor: assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> dden[0] >= (DW'(1) << WEIGHT_FRAC_BITS))
    else $error("divisor below one");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    dv[QUOT_BITS] |-> drem[QUOT_BITS] < NW'(dden[QUOT_BITS]))
    else $error("quotient overflow in divider");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vd) && $stable(dv) && $stable(v8))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ----- rtl/gaussian_weighted_burst_merge.sv -----
// gaussian weighted burst merge
// in_ch carries one colour sample per transaction: reference sample, seven
// aligned candidates and an inside mask. out_ch returns one merged sample
// per transaction. both channels are valid/ready; a transaction moves when
// both are high.
// config over an apb-style port: num_frames at 0x0, weight_scale at 0x8,
// 64-bit data, pready tied high. write only while the block is idle.
// throughput: one transaction per cycle, sustained while out_ch.ready stays
// high. every candidate has its own weight lane and the divider is a
// 16-stage pipeline, one quotient bit per stage.
// an input transaction reaches out_ch through the input register, queue,
// lane input, 7 weight stages, product, sum and 16 divide stages.
// reset: synchronous, clears all valid bits and the queue, num_frames goes
// to 1 and weight_scale to 0.5.
// when out_ch.valid is high and ready is low the back pipeline holds; the
// 4-entry queue and the input register keep taking transactions until full.
`default_nettype none

module gaussian_weighted_burst_merge import gwbm_pkg::*; #(
  parameter int MAX_FRAMES       = 8,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gwbm_in_if.sink          in_ch,
  gwbm_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  logic [3:0]  num_frames;
  logic [47:0] weight_scale;
  logic        fq_valid;
  gwbm_item_t  fq_item;
  logic        fq_ready;
  logic        qb_valid;
  gwbm_item_t  qb_item;
  logic        qb_ready;
  gwbm_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = gwbm_reg_e'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames   <= NUM_FRAMES_RST;
      weight_scale <= WEIGHT_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_NUM_FRAMES:   num_frames   <= pwdata[3:0];
        REG_WEIGHT_SCALE: weight_scale <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_FRAMES:   prdata = {60'b0, num_frames};
      REG_WEIGHT_SCALE: prdata = {16'b0, weight_scale};
      default:          prdata = '0;
    endcase
  end

  gwbm_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .num_frames (num_frames),
    .push_valid (fq_valid),
    .push_item  (fq_item),
    .push_ready (fq_ready)
  );

  gwbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_item  (fq_item),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_item   (qb_item),
    .pop_ready  (qb_ready)
  );

  gwbm_back #(
    .MAX_FRAMES       (MAX_FRAMES),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (qb_valid),
    .in_item      (qb_item),
    .in_ready     (qb_ready),
    .weight_scale (weight_scale),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample   (out_ch.merged_sample)
  );

endmodule

`default_nettype wire
